// File: design/touch_gesture_classifier_defines.svh
// ----------------------------------------------------------------------------
// touch_gesture_classifier_defines
// Assertion macros shared by the gesture classifier RTL. Each macro expects
// i_clk and i_rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_CLASSIFIER_DEFINES_SVH
`define TOUCH_GESTURE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication.
`define TGC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TGC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/tgc_pkg.sv
// ----------------------------------------------------------------------------
// tgc_pkg
// Types and constants for the touch gesture classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

    // Gesture codes on the result stream
    typedef enum logic [1:0] {
        GEST_SINGLE = 2'd0,
        GEST_DOUBLE = 2'd1,
        GEST_LONG   = 2'd2
    } t_gesture;

    // Configuration register indexes
    localparam logic [1:0] CFG_LONG_PRESS = 2'd0;
    localparam logic [1:0] CFG_DOUBLE_TAP = 2'd1;
    localparam logic [1:0] CFG_MARGIN     = 2'd2;

    // Register reset values
    localparam logic [15:0] LONG_PRESS_RST = 16'd1500;
    localparam logic [15:0] DOUBLE_TAP_RST = 16'd800;
    localparam logic [15:0] MARGIN_RST     = 16'd200;

    // Push the press start far away once a long press has been handled
    localparam logic [31:0] PUSH_AWAY_MS = 32'd99999;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        pressed;
        logic        point_valid;
        logic [11:0] x_coord;
        logic [11:0] y_coord;
    } t_poll;

    typedef struct packed {
        logic [15:0] long_press_ms;
        logic [15:0] double_tap_ms;
        logic [15:0] single_margin_ms;
    } t_cfg;

    typedef struct packed {
        t_gesture    gesture;
        logic [11:0] event_x;
        logic [11:0] event_y;
        logic        last_event;
    } t_event;

    // Up to two events raised by one poll, first one in ev0
    typedef struct packed {
        logic   v0;
        t_event ev0;
        logic   v1;
        t_event ev1;
    } t_evpair;

endpackage

// File: design/tgc_step.sv
// ----------------------------------------------------------------------------
// tgc_step
// Gesture state and per-poll decision logic. On each fire the poll is
// classified against the held state, the state advances and up to two
// events are presented on o_evs for the same cycle.
// ----------------------------------------------------------------------------
`include "touch_gesture_classifier_defines.svh"

module tgc_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  tgc_pkg::t_poll   i_poll,
    input  tgc_pkg::t_cfg    i_cfg,
    output tgc_pkg::t_evpair o_evs
);

    logic        r_was_down, n_was_down;
    logic        r_is_released, n_is_released;
    logic        r_tap_latched, n_tap_latched;
    logic        r_long_active, n_long_active;
    logic [31:0] r_press_start, n_press_start;
    logic [31:0] r_release_time, n_release_time;
    logic [11:0] r_pt_x, n_pt_x;
    logic [11:0] r_pt_y, n_pt_y;

    logic        take_point;
    logic [31:0] since_release;
    logic [31:0] since_press;
    logic [16:0] single_thresh;
    logic        fire_single;
    logic        fire_double;
    logic        fire_long;
    logic        is_press_edge;
    logic        is_release_edge;

    assign take_point      = i_poll.pressed & i_poll.point_valid;
    assign since_release   = i_poll.now_ms - r_release_time;
    assign since_press     = i_poll.now_ms - r_press_start;
    assign single_thresh   = {1'b0, i_cfg.long_press_ms} + {1'b0, i_cfg.single_margin_ms};
    assign is_press_edge   = i_poll.pressed & ~r_was_down;
    assign is_release_edge = ~i_poll.pressed & r_was_down;

    // Classify the poll and work out the next state
    always_comb begin
        n_pt_x         = take_point ? i_poll.x_coord : r_pt_x;
        n_pt_y         = take_point ? i_poll.y_coord : r_pt_y;
        n_is_released  = take_point ? 1'b0 : r_is_released;
        n_tap_latched  = r_tap_latched;
        n_long_active  = r_long_active;
        n_press_start  = r_press_start;
        n_release_time = r_release_time;
        n_was_down     = i_poll.pressed;
        fire_double    = 1'b0;
        fire_long      = 1'b0;

        // Confirm a single tap once the quiet time has run out
        fire_single = ~r_long_active & ~r_tap_latched & n_is_released &
                      (since_release > {15'd0, single_thresh});
        if (fire_single) begin
            n_tap_latched = 1'b1;
        end

        if (is_press_edge) begin
            n_press_start = i_poll.now_ms;
        end else if (is_release_edge) begin
            n_is_released = 1'b1;
            if (r_long_active) begin
                n_tap_latched = 1'b1;
                n_is_released = 1'b0;
                n_press_start = i_poll.now_ms + tgc_pkg::PUSH_AWAY_MS;
            end
            n_long_active = 1'b0;
            if (since_release < {16'd0, i_cfg.double_tap_ms}) begin
                n_tap_latched = 1'b1;
                fire_double   = 1'b1;
            end else begin
                n_tap_latched = 1'b0;
            end
            n_release_time = i_poll.now_ms;
        end

        // Held long enough: report a long press once
        if (i_poll.pressed && r_was_down && !r_long_active &&
            (since_press >= {16'd0, i_cfg.long_press_ms})) begin
            fire_long     = 1'b1;
            n_long_active = 1'b1;
            n_press_start = i_poll.now_ms + tgc_pkg::PUSH_AWAY_MS;
        end
    end

    // Order events: single tap first, then double tap or long press
    always_comb begin
        o_evs.v0             = fire_single | fire_double | fire_long;
        o_evs.v1             = fire_single & (fire_double | fire_long);
        o_evs.ev0.gesture    = fire_single ? tgc_pkg::GEST_SINGLE :
                               (fire_double ? tgc_pkg::GEST_DOUBLE : tgc_pkg::GEST_LONG);
        o_evs.ev0.event_x    = n_pt_x;
        o_evs.ev0.event_y    = n_pt_y;
        o_evs.ev0.last_event = ~o_evs.v1;
        o_evs.ev1.gesture    = fire_double ? tgc_pkg::GEST_DOUBLE : tgc_pkg::GEST_LONG;
        o_evs.ev1.event_x    = n_pt_x;
        o_evs.ev1.event_y    = n_pt_y;
        o_evs.ev1.last_event = 1'b1;
    end

    // Advance state on each processed poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_down     <= 1'b0;
            r_is_released  <= 1'b0;
            r_tap_latched  <= 1'b0;
            r_long_active  <= 1'b0;
            r_press_start  <= '0;
            r_release_time <= '0;
            r_pt_x         <= '0;
            r_pt_y         <= '0;
        end else if (i_fire) begin
            r_was_down     <= n_was_down;
            r_is_released  <= n_is_released;
            r_tap_latched  <= n_tap_latched;
            r_long_active  <= n_long_active;
            r_press_start  <= n_press_start;
            r_release_time <= n_release_time;
            r_pt_x         <= n_pt_x;
            r_pt_y         <= n_pt_y;
        end
    end

    // A release and a long press never come from the same poll
    `TGC_ASSERT_IMP(a_dbl_long_excl, i_fire, !(fire_double && fire_long), "double and long together")
    // After a long press fires, the block stays in long-press mode
    `TGC_ASSERT_NXT(a_long_sets_active, i_fire && fire_long, r_long_active, "long press not held")
    // Long-press mode is only held while the touch is down
    `TGC_ASSERT_IMP(a_rel_not_long, r_long_active, r_was_down, "long active while up")

endmodule

// File: design/touch_gesture_classifier.sv
// ----------------------------------------------------------------------------
// touch_gesture_classifier
// Tap, double-tap and long-press detector for a stream of touch polls.
// ----------------------------------------------------------------------------
// Each poll on the slave stream is classified from an input register into
// a two-event output stage, so a new poll is taken every cycle while events
// drain. A poll yields zero, one or two events; the master stream delivers
// one event per cycle while i_m_tready is high, so a poll that yields two
// events holds the next poll in the input register until its second event
// is taken. Thresholds are written through the cfg port and
// must only change while the block is idle.
// ----------------------------------------------------------------------------
`include "touch_gesture_classifier_defines.svh"

module touch_gesture_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration writes
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // Poll stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [31:0] now_ms, [32] pressed, [33] point_valid, [45:34] x_coord,
    // [57:46] y_coord, [63:58] zero
    input  logic [63:0] i_s_tdata,
    // Event stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [1:0] gesture, [13:2] event_x, [25:14] event_y, [31:26] zero
    output logic [31:0] o_m_tdata,
    output logic        o_m_tlast
);

    tgc_pkg::t_cfg     r_cfg;
    tgc_pkg::t_poll    r_in;
    logic              r_in_v;
    tgc_pkg::t_evpair  step_evs;
    tgc_pkg::t_event   r_ob0, r_ob1;
    logic              r_ob0_v, r_ob1_v;
    logic              take;
    logic              ob_free;
    logic              fire;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ms    <= tgc_pkg::LONG_PRESS_RST;
            r_cfg.double_tap_ms    <= tgc_pkg::DOUBLE_TAP_RST;
            r_cfg.single_margin_ms <= tgc_pkg::MARGIN_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                tgc_pkg::CFG_LONG_PRESS: r_cfg.long_press_ms    <= i_cfg_wdata;
                tgc_pkg::CFG_DOUBLE_TAP: r_cfg.double_tap_ms    <= i_cfg_wdata;
                tgc_pkg::CFG_MARGIN:     r_cfg.single_margin_ms <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake between the stages
    assign take       = r_ob0_v & i_m_tready;
    assign ob_free    = ~r_ob0_v | (take & ~r_ob1_v);
    assign fire       = r_in_v & ob_free;
    assign o_s_tready = ~r_in_v | fire;

    // Input register: hold the request until the core takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_s_tready) begin
            r_in_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in.now_ms      <= i_s_tdata[31:0];
            r_in.pressed     <= i_s_tdata[32];
            r_in.point_valid <= i_s_tdata[33];
            r_in.x_coord     <= i_s_tdata[45:34];
            r_in.y_coord     <= i_s_tdata[57:46];
        end
    end

    tgc_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_poll  (r_in),
        .i_cfg   (r_cfg),
        .o_evs   (step_evs)
    );

    // Output stage: load a fresh pair, or shift the second event forward
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob0_v <= 1'b0;
            r_ob1_v <= 1'b0;
        end else if (fire) begin
            r_ob0_v <= step_evs.v0;
            r_ob1_v <= step_evs.v1;
        end else if (take) begin
            r_ob0_v <= r_ob1_v;
            r_ob1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_ob0 <= step_evs.ev0;
            r_ob1 <= step_evs.ev1;
        end else if (take) begin
            r_ob0 <= r_ob1;
        end
    end

    assign o_m_tvalid = r_ob0_v;
    assign o_m_tdata  = {6'd0, r_ob0.event_y, r_ob0.event_x, r_ob0.gesture};
    assign o_m_tlast  = r_ob0.last_event;

    // Second slot only ever backs up a filled first slot
    `TGC_ASSERT_IMP(a_ob_order, r_ob1_v, r_ob0_v, "second event without first")
    // The first of a pair never closes the poll
    `TGC_ASSERT_IMP(a_pair_last, r_ob1_v, !r_ob0.last_event && r_ob1.last_event, "pair last flags")
    // Draining the last event with nothing new empties the stage
    `TGC_ASSERT_NXT(a_drain, take && !r_ob1_v && !fire, !r_ob0_v, "event stage not emptied")

endmodule

// File: sim/touch_gesture_classifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_gesture_classifier_tb
// Self-checking bench for the tap, double-tap and long-press classifier.
// ----------------------------------------------------------------------------
// Touch polls go in on the slave stream and gesture events come out on the
// master stream. A behavioral tracker of the classifier predicts the events
// of each accepted poll. A checker compares every event, field by field,
// against the oldest prediction. Directed gestures cover threshold edges,
// two events in one poll and timestamp wrap. Random gesture sequences then
// run under several threshold settings, with random gaps on both streams.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_tb;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_addr  = tgc_pkg::CFG_LONG_PRESS;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    // [31:0] now_ms, [32] pressed, [33] point_valid, [45:34] x_coord,
    // [57:46] y_coord, [63:58] zero
    logic [63:0] i_s_tdata   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    // [1:0] gesture, [13:2] event_x, [25:14] event_y, [31:26] zero
    logic [31:0] o_m_tdata;
    logic        o_m_tlast;

    // Thresholds as last written
    logic [15:0] cfg_long   = tgc_pkg::LONG_PRESS_RST;
    logic [15:0] cfg_double = tgc_pkg::DOUBLE_TAP_RST;
    logic [15:0] cfg_margin = tgc_pkg::MARGIN_RST;

    // Tracked touch state
    logic        held_prev       = 1'b0;
    logic        release_pending = 1'b0;
    logic        tap_done        = 1'b0;
    logic        long_held       = 1'b0;
    logic [31:0] hold_start      = '0;
    logic [31:0] last_release    = '0;
    logic [11:0] lat_x           = '0;
    logic [11:0] lat_y           = '0;

    tgc_pkg::t_event expected_events[$];
    int          event_errors = 0;
    int          polls_sent   = 0;
    logic [31:0] poll_clock   = '0;
    logic        idle_on      = 1'b1;
    int          stall_left   = 0;

    touch_gesture_classifier dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Classify one poll and queue the events it raises
    function automatic void classify_poll(input tgc_pkg::t_poll p);
        tgc_pkg::t_gesture found[$];
        tgc_pkg::t_event   ev;
        if (p.pressed && p.point_valid) begin
            release_pending = 1'b0;
            lat_x = p.x_coord;
            lat_y = p.y_coord;
        end
        // Single tap confirmed once the wait after release has run out
        if (!long_held && !tap_done && release_pending &&
            (p.now_ms - last_release) > ({16'd0, cfg_long} + {16'd0, cfg_margin})) begin
            tap_done = 1'b1;
            found.push_back(tgc_pkg::GEST_SINGLE);
        end
        if (p.pressed && !held_prev) begin
            hold_start = p.now_ms;
        end else if (!p.pressed && held_prev) begin
            release_pending = 1'b1;
            if (long_held) begin
                tap_done = 1'b1;
                release_pending = 1'b0;
                hold_start = p.now_ms + tgc_pkg::PUSH_AWAY_MS;
            end
            long_held = 1'b0;
            if ((p.now_ms - last_release) < {16'd0, cfg_double}) begin
                tap_done = 1'b1;
                found.push_back(tgc_pkg::GEST_DOUBLE);
            end else begin
                tap_done = 1'b0;
            end
            last_release = p.now_ms;
        end
        if (p.pressed && held_prev && !long_held &&
            (p.now_ms - hold_start) >= {16'd0, cfg_long}) begin
            found.push_back(tgc_pkg::GEST_LONG);
            long_held = 1'b1;
            hold_start = p.now_ms + tgc_pkg::PUSH_AWAY_MS;
        end
        held_prev = p.pressed;
        foreach (found[i]) begin
            ev.gesture    = found[i];
            ev.event_x    = lat_x;
            ev.event_y    = lat_y;
            ev.last_event = (i == found.size() - 1);
            expected_events.push_back(ev);
        end
    endfunction

    function automatic logic chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [11:0] rand_coord();
        return 12'($urandom_range(0, 4095));
    endfunction

    // Time step between polls: mostly short, often right at a threshold
    function automatic logic [31:0] pick_gap(input int thr);
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 5) return $urandom_range(0, 60);
        if (r < 8) begin
            v = thr + int'($urandom_range(0, 4)) - 2;
            return (v < 0) ? 32'd0 : 32'(v);
        end
        if (r < 9) return $urandom_range(0, 2 * thr + 1);
        return $urandom;
    endfunction

    // Advance the poll clock and send one poll request
    task automatic send_poll(input logic [31:0] dt, input logic pr, input logic pv,
                             input logic [11:0] x, input logic [11:0] y);
        tgc_pkg::t_poll p;
        poll_clock    = poll_clock + dt;
        p.now_ms      = poll_clock;
        p.pressed     = pr;
        p.point_valid = pv;
        p.x_coord     = x;
        p.y_coord     = y;
        if (idle_on && chance(20)) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, y, x, pv, pr, p.now_ms};
        do @(posedge i_clk); while (!o_s_tready);
        classify_poll(p);
        polls_sent++;
    endtask

    // Hold polls back until every event is out and the pipeline is empty
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write all three thresholds; the block must be idle
    task automatic set_config(input logic [15:0] lp, input logic [15:0] dbl,
                              input logic [15:0] mg);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= tgc_pkg::CFG_LONG_PRESS;
        i_cfg_wdata <= lp;
        @(posedge i_clk);
        cfg_long     = lp;
        i_cfg_addr  <= tgc_pkg::CFG_DOUBLE_TAP;
        i_cfg_wdata <= dbl;
        @(posedge i_clk);
        cfg_double   = dbl;
        i_cfg_addr  <= tgc_pkg::CFG_MARGIN;
        i_cfg_wdata <= mg;
        @(posedge i_clk);
        cfg_margin   = mg;
        i_cfg_wr_en <= 1'b0;
    endtask

    // Random gesture sequences shaped around the current thresholds
    task automatic run_gestures(input int count);
        int          start;
        int          kind;
        int          thr_long;
        int          thr_double;
        int          thr_single;
        logic [11:0] px;
        logic [11:0] py;
        start      = polls_sent;
        thr_long   = int'(cfg_long);
        thr_double = int'(cfg_double);
        thr_single = thr_long + int'(cfg_margin);
        while (polls_sent - start < count) begin
            kind = $urandom_range(0, 9);
            px   = rand_coord();
            py   = rand_coord();
            if (kind < 4) begin
                // tap, maybe held a little, then some quiet polls
                send_poll(pick_gap(thr_double), 1'b1, chance(85), px, py);
                repeat ($urandom_range(0, 2))
                    send_poll(pick_gap(thr_long), 1'b1, chance(50),
                              rand_coord(), rand_coord());
                send_poll(pick_gap(thr_double), 1'b0, chance(20),
                          rand_coord(), rand_coord());
                repeat ($urandom_range(0, 2))
                    send_poll(pick_gap(thr_single), 1'b0, chance(20),
                              rand_coord(), rand_coord());
            end else if (kind < 7) begin
                // long hold toward the long-press threshold
                send_poll(pick_gap(thr_single), 1'b1, chance(85), px, py);
                repeat ($urandom_range(1, 3))
                    send_poll(pick_gap(thr_long), 1'b1, chance(50),
                              rand_coord(), rand_coord());
                send_poll(pick_gap(thr_double), 1'b0, chance(20), px, py);
            end else if (kind < 9) begin
                // two quick taps
                repeat (2) begin
                    send_poll(pick_gap(thr_double), 1'b1, chance(85),
                              rand_coord(), rand_coord());
                    send_poll(pick_gap(thr_double), 1'b0, chance(20), px, py);
                end
            end else begin
                // noise
                repeat ($urandom_range(1, 4))
                    send_poll(chance(50) ? $urandom : $urandom_range(0, 100),
                              chance(50), chance(50),
                              rand_coord(), rand_coord());
            end
        end
    endtask

    // Tap, release, and the single-tap confirm just past the margin
    task automatic test_single_tap();
        send_poll(10000, 1'b1, 1'b1, 12'hFFF, 12'h000);
        // a point on a poll without press is dropped
        send_poll(30, 1'b0, 1'b1, 12'h123, 12'h456);
        send_poll(1700, 1'b0, 1'b0, 12'h000, 12'h000);
        send_poll(1, 1'b0, 1'b0, 12'h000, 12'h000);
    endtask

    // Release gaps one below and exactly at the double-tap window
    task automatic test_double_tap();
        send_poll(30, 1'b1, 1'b1, 12'h000, 12'hFFF);
        send_poll(30, 1'b0, 1'b0, 12'h000, 12'h000);
        send_poll(30, 1'b1, 1'b1, 12'hABC, 12'h555);
        send_poll(769, 1'b0, 1'b0, 12'h000, 12'h000);
        send_poll(30, 1'b1, 1'b1, 12'h5A5, 12'hA5A);
        send_poll(770, 1'b0, 1'b0, 12'h000, 12'h000);
        send_poll(1701, 1'b0, 1'b0, 12'h000, 12'h000);
    endtask

    // Long press at exactly the hold time, then release after it
    task automatic test_long_press();
        send_poll(30, 1'b1, 1'b1, 12'd800, 12'd400);
        send_poll(1499, 1'b1, 1'b1, 12'd801, 12'd401);
        send_poll(1, 1'b1, 1'b1, 12'd802, 12'd402);
        send_poll(30, 1'b1, 1'b1, 12'd803, 12'd403);
        send_poll(30, 1'b0, 1'b0, 12'd0, 12'd0);
        send_poll(2000, 1'b0, 1'b0, 12'd0, 12'd0);
    endtask

    // Single tap and long press raised by the same poll
    task automatic test_two_events();
        send_poll(30, 1'b1, 1'b1, 12'd111, 12'd222);
        send_poll(30, 1'b0, 1'b0, 12'd0, 12'd0);
        // press without a point keeps the release pending
        send_poll(300, 1'b1, 1'b0, 12'd999, 12'd999);
        send_poll(1500, 1'b1, 1'b0, 12'd333, 12'd444);
        send_poll(30, 1'b0, 1'b0, 12'd0, 12'd0);
    endtask

    // Long press held across the timestamp wrap
    task automatic test_time_wrap();
        send_poll(32'hFFFF_FF00 - poll_clock, 1'b0, 1'b0, 12'd0, 12'd0);
        send_poll(30, 1'b1, 1'b1, 12'd4000, 12'd17);
        send_poll(1500, 1'b1, 1'b1, 12'd4001, 12'd18);
        send_poll(30, 1'b0, 1'b0, 12'd0, 12'd0);
    endtask

    // Zero thresholds are used as written
    task automatic test_zero_registers();
        wait_drained();
        set_config(16'd0, 16'd0, 16'd0);
        run_gestures(60);
    endtask

    // Smallest and largest threshold settings
    task automatic test_limits();
        wait_drained();
        set_config(16'd1, 16'd1, 16'd0);
        run_gestures(150);
        wait_drained();
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_gestures(150);
    endtask

    task automatic test_default_random();
        wait_drained();
        set_config(tgc_pkg::LONG_PRESS_RST, tgc_pkg::DOUBLE_TAP_RST, tgc_pkg::MARGIN_RST);
        run_gestures(500);
    endtask

    task automatic test_random_config();
        repeat (3) begin
            wait_drained();
            set_config(16'($urandom_range(1, 4000)), 16'($urandom_range(1, 2000)),
                       16'($urandom_range(0, 1000)));
            run_gestures(150);
        end
        wait_drained();
        set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                   16'($urandom_range(0, 65535)));
        run_gestures(150);
    endtask

    // Full rate on both streams
    task automatic test_no_idle();
        wait_drained();
        idle_on = 1'b0;
        set_config(16'($urandom_range(1, 3000)), 16'($urandom_range(1, 1500)),
                   16'($urandom_range(0, 800)));
        run_gestures(250);
    endtask

    // Random stall bursts on the event stream
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && chance(15)) begin
            i_m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Compare each event request with the oldest prediction
    always @(posedge i_clk) begin
        tgc_pkg::t_event got;
        tgc_pkg::t_event want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.gesture    = tgc_pkg::t_gesture'(o_m_tdata[1:0]);
            got.event_x    = o_m_tdata[13:2];
            got.event_y    = o_m_tdata[25:14];
            got.last_event = o_m_tlast;
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected event, expected none, got gesture %0d x %0d y %0d last %0b",
                         $time, got.gesture, got.event_x, got.event_y, got.last_event);
                event_errors++;
            end else begin
                want = expected_events.pop_front();
                if (got.gesture !== want.gesture) begin
                    $display("%0t: gesture mismatch, expected %0d, got %0d",
                             $time, want.gesture, got.gesture);
                    event_errors++;
                end
                if (got.event_x !== want.event_x) begin
                    $display("%0t: event_x mismatch, expected %0d, got %0d",
                             $time, want.event_x, got.event_x);
                    event_errors++;
                end
                if (got.event_y !== want.event_y) begin
                    $display("%0t: event_y mismatch, expected %0d, got %0d",
                             $time, want.event_y, got.event_y);
                    event_errors++;
                end
                if (got.last_event !== want.last_event) begin
                    $display("%0t: last_event mismatch, expected %0b, got %0b",
                             $time, want.last_event, got.last_event);
                    event_errors++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_single_tap();
        test_double_tap();
        test_long_press();
        test_two_events();
        test_time_wrap();
        test_zero_registers();
        test_limits();
        test_default_random();
        test_random_config();
        test_no_idle();
        wait_drained();
        if (event_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Abort a hung run
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/tgc_pkg.sv
design/tgc_step.sv
design/touch_gesture_classifier.sv
sim/touch_gesture_classifier_tb.sv
